[rtl/core/ternary_sign_magnitude_alu_macros.svh]
// Assertion macros for the ternary sign-magnitude ALU.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TERNARY_SIGN_MAGNITUDE_ALU_MACROS_SVH
`define TERNARY_SIGN_MAGNITUDE_ALU_MACROS_SVH

// same-cycle implication, disabled during reset
`define TSMA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TSMA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tsma_pkg.sv]
// Shared types and constants of the ternary sign-magnitude ALU.
// No dependencies; used by tsma_serial_unit and ternary_sign_magnitude_alu.
package tsma_pkg;

   localparam int WordTritsDef = 27;
   localparam int FieldTrits   = 26;
   localparam int FieldBits    = 2 * FieldTrits;

   localparam logic [2:0] ModeAdd = 3'd0;
   localparam logic [2:0] ModeSub = 3'd1;
   localparam logic [2:0] ModeMul = 3'd2;
   localparam logic [2:0] ModeDiv = 3'd3;
   localparam logic [2:0] ModeCmp = 3'd4;

   typedef struct packed {
      logic [2:0]           mode;
      logic                 a_negative;
      logic [FieldBits-1:0] a_digits;
      logic                 b_negative;
      logic [FieldBits-1:0] b_digits;
   } req_type;

   typedef struct packed {
      logic                 r_negative;
      logic [FieldBits-1:0] r_digits;
      logic                 is_less;
      logic                 is_equal;
      logic                 is_greater;
      logic                 div_zero;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic sub;
   } eng_cmd_type;

   typedef struct packed {
      logic done;
      logic cout;
   } eng_sts_type;

endpackage

[rtl/core/ternary_sign_magnitude_alu.sv]
// Ternary sign-magnitude ALU top level: sequencer around a trit-serial adder.
// Depends on tsma_pkg, tsma_serial_unit and ternary_sign_magnitude_alu_macros.svh.
//
//   channel  | ports                           | moves
//   ---------+---------------------------------+---------------------------------
//   request  | req_valid req_stall req_data    | mode, signs, packed operand trits
//   response | rsp_valid rsp_stall rsp_data    | sign, packed result trits, flags
//
// Each serial pass issues a start, steps through the L trits and raises done, with L = WORD_TRITS.
// Both operands are first normalised by one pass each; add/subtract then takes one pass, or
// a second one when magnitudes are subtracted and |a| < |b|; compare takes one pass; multiply
// adds passes per multiplier trit and divide runs trial subtractions per quotient trit.
// One request is in work at a time; the next is taken while a response waits.
// Synchronous active-high reset clears the sequencer and the response valid.
// A stalled response holds in its output register; the sequencer waits in its final state.
`include "ternary_sign_magnitude_alu_macros.svh"

module ternary_sign_magnitude_alu #(
   parameter int WORD_TRITS = tsma_pkg::WordTritsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsma_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsma_pkg::rsp_type rsp_data
);

   localparam int MAG  = WORD_TRITS - 1;
   localparam int LEN  = WORD_TRITS;
   localparam int W    = 2 * LEN;
   localparam int TcW  = $clog2(MAG + 1);
   localparam int IoT  = (MAG < tsma_pkg::FieldTrits) ? MAG : tsma_pkg::FieldTrits;

   typedef enum logic [14:0] {
      StIdle     = 15'b000000000000001,
      StNormA    = 15'b000000000000010,
      StNormB    = 15'b000000000000100,
      StDispatch = 15'b000000000001000,
      StPass     = 15'b000000000010000,
      StAddFin   = 15'b000000000100000,
      StSubFin1  = 15'b000000001000000,
      StSubFin2  = 15'b000000010000000,
      StCmpFin   = 15'b000000100000000,
      StMulShift = 15'b000001000000000,
      StMulAdd   = 15'b000010000000000,
      StMulAcc   = 15'b000100000000000,
      StDivShift = 15'b001000000000000,
      StDivTry   = 15'b010000000000000,
      StDone     = 15'b100000000000000
   } state_type;

   function automatic logic [W-1:0] load_raw(input logic [tsma_pkg::FieldBits-1:0] d);
      logic [W-1:0] v;
      v = '0;
      for (int i = 0; i < IoT; i++) begin
         v[2*i +: 2] = d[2*i +: 2];
      end
      return v;
   endfunction

   function automatic logic [tsma_pkg::FieldBits-1:0] to_field(input logic [W-1:0] v);
      logic [tsma_pkg::FieldBits-1:0] f;
      f = '0;
      for (int i = 0; i < IoT; i++) begin
         f[2*i +: 2] = v[2*i +: 2];
      end
      return f;
   endfunction

   // drop the guard trit: reduce modulo 3^MAG
   function automatic logic [W-1:0] mask_top(input logic [W-1:0] v);
      logic [W-1:0] r;
      r = v;
      r[W-1:W-2] = 2'b00;
      return r;
   endfunction

   function automatic logic [W-1:0] shl(input logic [W-1:0] v);
      return mask_top({v[W-3:0], 2'b00});
   endfunction

   state_type         state_ff, state_in, ret_ff, ret_in;
   logic [2:0]        mode_ff, mode_in;
   logic              as_ff, as_in, bs_ff, bs_in;
   logic              sa_ff, sa_in, sb_ff, sb_in, rs_ff, rs_in;
   logic [W-1:0]      ra_ff, ra_in, rb_ff, rb_in, wk_ff, wk_in, r_ff, r_in;
   logic [1:0]        qd_ff, qd_in;
   logic [TcW-1:0]    tcnt_ff, tcnt_in;
   logic              lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in, dz_ff, dz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tsma_pkg::rsp_type rsp_ff, rsp_in;

   tsma_pkg::eng_cmd_type eng_cmd;
   tsma_pkg::eng_sts_type eng_sts;
   logic [W-1:0]          eng_acc, eng_opd, eng_res;

   logic a_nz, b_nz, as_eff, bs_eff, bs_op, a_gt, eq_mag;

   tsma_serial_unit #(.LEN_TRITS(LEN)) u_serial (
      .clock    (clock),
      .reset    (reset),
      .cmd      (eng_cmd),
      .acc_load (eng_acc),
      .opd_load (eng_opd),
      .result   (eng_res),
      .sts      (eng_sts)
   );

   assign req_stall = (state_ff != StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign a_nz   = (ra_ff != '0);
   assign b_nz   = (rb_ff != '0);
   assign as_eff = as_ff & a_nz;
   assign bs_eff = bs_ff & b_nz;
   assign bs_op  = (mode_ff == tsma_pkg::ModeSub) ? (b_nz & ~bs_ff) : bs_eff;
   assign eq_mag = !eng_sts.cout && (eng_res == '0);
   assign a_gt   = !eng_sts.cout && !eq_mag;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      mode_in      = mode_ff;
      as_in        = as_ff;
      bs_in        = bs_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      rs_in        = rs_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      wk_in        = wk_ff;
      r_in         = r_ff;
      qd_in        = qd_ff;
      tcnt_in      = tcnt_ff;
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      gt_in        = gt_ff;
      dz_in        = dz_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      eng_cmd      = '0;
      eng_acc      = '0;
      eng_opd      = '0;

      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               mode_in = req_data.mode;
               as_in   = req_data.a_negative;
               bs_in   = req_data.b_negative;
               ra_in   = load_raw(req_data.a_digits);
               rb_in   = load_raw(req_data.b_digits);
               r_in    = '0;
               rs_in   = 1'b0;
               lt_in   = 1'b0;
               eq_in   = 1'b0;
               gt_in   = 1'b0;
               dz_in   = 1'b0;
               // normalise digit code three by adding zero
               eng_cmd.start = 1'b1;
               eng_acc       = load_raw(req_data.a_digits);
               state_in      = StPass;
               ret_in        = StNormA;
            end
         end
         StNormA: begin
            ra_in         = mask_top(eng_res);
            eng_cmd.start = 1'b1;
            eng_acc       = rb_ff;
            state_in      = StPass;
            ret_in        = StNormB;
         end
         StNormB: begin
            rb_in    = mask_top(eng_res);
            state_in = StDispatch;
         end
         StDispatch: begin
            sa_in   = as_eff;
            sb_in   = bs_op;
            tcnt_in = '0;
            wk_in   = '0;
            case (mode_ff)
               tsma_pkg::ModeAdd, tsma_pkg::ModeSub: begin
                  eng_cmd.start = 1'b1;
                  eng_cmd.sub   = (as_eff != bs_op);
                  eng_acc       = ra_ff;
                  eng_opd       = rb_ff;
                  state_in      = StPass;
                  ret_in        = (as_eff == bs_op) ? StAddFin : StSubFin1;
               end
               tsma_pkg::ModeCmp: begin
                  eng_cmd.start = 1'b1;
                  eng_cmd.sub   = 1'b1;
                  eng_acc       = ra_ff;
                  eng_opd       = rb_ff;
                  state_in      = StPass;
                  ret_in        = StCmpFin;
               end
               tsma_pkg::ModeMul: begin
                  state_in = StMulShift;
               end
               tsma_pkg::ModeDiv: begin
                  if (!b_nz) begin
                     dz_in    = 1'b1;
                     state_in = StDone;
                  end else begin
                     state_in = StDivShift;
                  end
               end
               default: begin
                  state_in = StDone;
               end
            endcase
         end
         StPass: begin
            if (eng_sts.done) begin
               state_in = ret_ff;
            end
         end
         StAddFin: begin
            r_in     = mask_top(eng_res);
            rs_in    = sa_ff;
            state_in = StDone;
         end
         StSubFin1: begin
            if (!eng_sts.cout) begin
               r_in     = eng_res;
               rs_in    = sa_ff;
               state_in = StDone;
            end else begin
               // a below b: take b - a instead
               eng_cmd.start = 1'b1;
               eng_cmd.sub   = 1'b1;
               eng_acc       = rb_ff;
               eng_opd       = ra_ff;
               state_in      = StPass;
               ret_in        = StSubFin2;
            end
         end
         StSubFin2: begin
            r_in     = eng_res;
            rs_in    = sb_ff;
            state_in = StDone;
         end
         StCmpFin: begin
            if (sa_ff == sb_ff && eq_mag) begin
               eq_in = 1'b1;
            end else if (sa_ff != sb_ff) begin
               lt_in = sa_ff;
               gt_in = ~sa_ff;
            end else if (!sa_ff) begin
               lt_in = eng_sts.cout;
               gt_in = ~eng_sts.cout;
            end else begin
               lt_in = a_gt;
               gt_in = ~a_gt;
            end
            state_in = StDone;
         end
         StMulShift: begin
            wk_in    = shl(wk_ff);
            qd_in    = rb_ff[W-3:W-4];
            rb_in    = shl(rb_ff);
            tcnt_in  = tcnt_ff + 1'b1;
            state_in = StMulAdd;
         end
         StMulAdd: begin
            if (qd_ff == 2'd0) begin
               if (tcnt_ff == TcW'(MAG)) begin
                  r_in     = wk_ff;
                  rs_in    = sa_ff ^ sb_ff;
                  state_in = StDone;
               end else begin
                  state_in = StMulShift;
               end
            end else begin
               eng_cmd.start = 1'b1;
               eng_acc       = wk_ff;
               eng_opd       = ra_ff;
               state_in      = StPass;
               ret_in        = StMulAcc;
            end
         end
         StMulAcc: begin
            wk_in    = mask_top(eng_res);
            qd_in    = qd_ff - 2'd1;
            state_in = StMulAdd;
         end
         StDivShift: begin
            // bring down the next dividend trit into the partial remainder
            wk_in    = {wk_ff[W-3:0], ra_ff[W-3:W-4]};
            ra_in    = shl(ra_ff);
            qd_in    = 2'd0;
            tcnt_in  = tcnt_ff + 1'b1;
            state_in = StDivTry;
         end
         StDivTry: begin
            eng_cmd.start = 1'b1;
            eng_cmd.sub   = 1'b1;
            eng_acc       = wk_ff;
            eng_opd       = rb_ff;
            state_in      = StPass;
            ret_in        = StDone;
            // the check after the trial runs in StDone's divide branch
         end
         StDone: begin
            if (mode_ff == tsma_pkg::ModeDiv && ret_ff == StDone && b_nz) begin
               // trial subtraction of the divisor has just finished
               ret_in = StIdle;
               if (!eng_sts.cout) begin
                  wk_in    = eng_res;
                  qd_in    = qd_ff + 2'd1;
                  state_in = StDivTry;
               end else begin
                  r_in = {r_ff[W-3:0], qd_ff};
                  if (tcnt_ff == TcW'(MAG)) begin
                     rs_in  = sa_ff ^ sb_ff;
                     ret_in = StIdle;
                  end else begin
                     state_in = StDivShift;
                  end
               end
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.r_negative = rs_ff & (r_ff != '0);
               rsp_in.r_digits   = to_field(r_ff);
               rsp_in.is_less    = lt_ff;
               rsp_in.is_equal   = eq_ff;
               rsp_in.is_greater = gt_ff;
               rsp_in.div_zero   = dz_ff;
               rsp_valid_in      = 1'b1;
               state_in          = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ret_ff       <= StIdle;
         rsp_valid_ff <= 1'b0;
         tcnt_ff      <= '0;
         qd_ff        <= 2'd0;
         mode_ff      <= tsma_pkg::ModeAdd;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         tcnt_ff      <= tcnt_in;
         qd_ff        <= qd_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      as_ff  <= as_in;
      bs_ff  <= bs_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      rs_ff  <= rs_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      wk_ff  <= wk_in;
      r_ff   <= r_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
      gt_ff  <= gt_in;
      dz_ff  <= dz_in;
      rsp_ff <= rsp_in;
   end

   `TSMA_ASSERT_IMP(a_done_in_pass, clock, reset, eng_sts.done, state_ff == StPass,
      "serial unit finished outside a pass")
   `TSMA_ASSERT_IMP(a_rsp_from_done, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff),
      $past(state_ff == StDone), "response loaded outside the final state")
   `TSMA_ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid_ff && rsp_ff.div_zero,
      rsp_ff.r_digits == '0 && !rsp_ff.r_negative, "divide by zero with non-zero result")
   `TSMA_ASSERT_IMP(a_qdigit, clock, reset, state_ff == StDivTry, qd_ff != 2'd3,
      "quotient trit out of range")

endmodule

[rtl/core/tsma_serial_unit.sv]
// Trit-serial add/subtract unit: result = acc + opd or acc - opd, one trit a cycle.
// Depends on tsma_pkg for the command and status structs.
module tsma_serial_unit #(
   parameter int LEN_TRITS = tsma_pkg::WordTritsDef
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tsma_pkg::eng_cmd_type      cmd,
   input  logic [2*LEN_TRITS-1:0]     acc_load,
   input  logic [2*LEN_TRITS-1:0]     opd_load,
   output logic [2*LEN_TRITS-1:0]     result,
   output tsma_pkg::eng_sts_type      sts
);

   localparam int W    = 2 * LEN_TRITS;
   localparam int CntW = $clog2(LEN_TRITS);

   logic [W-1:0]    acc_ff, opd_ff, tmp_ff;
   logic [CntW-1:0] cnt_ff;
   logic            busy_ff, done_ff, sub_ff;
   logic [1:0]      carry_ff;

   logic [1:0] x, y, digit, carry_nx;
   logic [3:0] s;

   assign x = acc_ff[1:0];
   assign y = opd_ff[1:0];

   always_comb begin
      if (sub_ff) begin
         // bias by three so the difference stays non-negative
         s = 4'(x) + 4'd3 - 4'(y) - 4'(carry_ff);
         if (s >= 4'd3) begin
            digit    = 2'(s - 4'd3);
            carry_nx = 2'd0;
         end else begin
            digit    = 2'(s);
            carry_nx = 2'd1;
         end
      end else begin
         s = 4'(x) + 4'(y) + 4'(carry_ff);
         if (s < 4'd3) begin
            digit    = 2'(s);
            carry_nx = 2'd0;
         end else if (s < 4'd6) begin
            digit    = 2'(s - 4'd3);
            carry_nx = 2'd1;
         end else begin
            digit    = 2'(s - 4'd6);
            carry_nx = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
         carry_ff <= 2'd0;
         sub_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            acc_ff   <= acc_load;
            opd_ff   <= opd_load;
            busy_ff  <= 1'b1;
            cnt_ff   <= '0;
            carry_ff <= 2'd0;
            sub_ff   <= cmd.sub;
         end else if (busy_ff) begin
            // rotate operands, shift result in from the top
            acc_ff   <= {x, acc_ff[W-1:2]};
            opd_ff   <= {y, opd_ff[W-1:2]};
            tmp_ff   <= {digit, tmp_ff[W-1:2]};
            carry_ff <= carry_nx;
            cnt_ff   <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(LEN_TRITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result   = tmp_ff;
   assign sts.done = done_ff;
   assign sts.cout = (carry_ff != 2'd0);

endmodule

[test/tsma_checker.sv]
// Checker for the ternary sign-magnitude ALU: watches both channels, predicts
// each response from the accepted request and compares it whole. Uses tsma_pkg.
`timescale 1ns / 1ps

module tsma_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tsma_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tsma_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import tsma_pkg::*;

   localparam int MagTrits   = WordTritsDef - 1;
   localparam int QueueDepth = 8;

   // ring of predicted responses, in request order
   rsp_type awaited_rsp [QueueDepth];
   int      wr_count;
   int      rd_count;

   function automatic longint unsigned trit_modulus();
      longint unsigned m;
      m = 1;
      for (int i = 0; i < MagTrits; i++) m = m * 3;
      return m;
   endfunction

   function automatic longint unsigned trits_to_value(logic [FieldBits-1:0] bits,
                                                       longint unsigned m);
      longint unsigned v;
      longint unsigned d;
      v = 0;
      for (int i = MagTrits - 1; i >= 0; i--) begin
         d = (i < FieldTrits) ? longint'(bits[2*i +: 2]) : 0;
         v = (v * 3 + d) % m;
      end
      return v;
   endfunction

   function automatic logic [FieldBits-1:0] value_to_trits(longint unsigned v);
      logic [FieldBits-1:0] bits;
      bits = '0;
      for (int i = 0; i < MagTrits && i < FieldTrits; i++) begin
         bits[2*i +: 2] = 2'(v % 3);
         v = v / 3;
      end
      return bits;
   endfunction

   function automatic longint unsigned wrapped_product(longint unsigned x,
                                                       longint unsigned y,
                                                       longint unsigned m);
      longint unsigned r;
      r = 0;
      while (y != 0) begin
         if (y[0]) r = (r + x) % m;
         x = (x * 2) % m;
         y = y >> 1;
      end
      return r;
   endfunction

   function automatic rsp_type alu_result(req_type q);
      rsp_type         o;
      longint unsigned m, a, b, r;
      logic            as, bs, rs;
      m = trit_modulus();
      a = trits_to_value(q.a_digits, m);
      b = trits_to_value(q.b_digits, m);
      as = (a == 0) ? 1'b0 : q.a_negative;
      bs = (b == 0) ? 1'b0 : q.b_negative;
      o = '0;
      r = 0;
      rs = 1'b0;
      if (q.mode == ModeSub) bs = (b != 0) ? !bs : 1'b0;
      case (q.mode)
         ModeAdd, ModeSub: begin
            if (as == bs) begin
               r = (a + b) % m;
               rs = as;
            end else if (a >= b) begin
               r = a - b;
               rs = as;
            end else begin
               r = b - a;
               rs = bs;
            end
         end
         ModeMul: begin
            r = wrapped_product(a, b, m);
            rs = as != bs;
         end
         ModeDiv: begin
            if (b == 0) o.div_zero = 1'b1;
            else begin
               r = a / b;
               rs = as != bs;
            end
         end
         ModeCmp: begin
            if (as == bs && a == b) o.is_equal = 1'b1;
            else if (as != bs) begin
               o.is_less = as;
               o.is_greater = !as;
            end else if (!as) begin
               o.is_less = a < b;
               o.is_greater = !(a < b);
            end else begin
               o.is_less = a > b;
               o.is_greater = !(a > b);
            end
         end
         default: ;
      endcase
      o.r_negative = (r != 0) && rs;
      o.r_digits = value_to_trits(r);
      return o;
   endfunction

   assign pending = wr_count - rd_count;

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         fail_count <= 0;
         wr_count   <= 0;
         rd_count   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp[wr_count % QueueDepth] <= alu_result(req_data);
            wr_count <= wr_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (wr_count == rd_count) begin
               $display("%t unexpected response: %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = awaited_rsp[rd_count % QueueDepth];
               rd_count <= rd_count + 1;
               if (exp_rsp !== rsp_data) begin
                  $display("%t mismatch: expected sign %b digits %h flags %b%b%b%b", $time,
                           exp_rsp.r_negative, exp_rsp.r_digits, exp_rsp.is_less,
                           exp_rsp.is_equal, exp_rsp.is_greater, exp_rsp.div_zero);
                  $display("%t            actual sign %b digits %h flags %b%b%b%b", $time,
                           rsp_data.r_negative, rsp_data.r_digits, rsp_data.is_less,
                           rsp_data.is_equal, rsp_data.is_greater, rsp_data.div_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[test/tb.sv]
// Testbench top for ternary_sign_magnitude_alu: clock, reset, request stimulus
// and verdict. Depends on tsma_pkg, tsma_checker and the RTL.
`timescale 1ns / 1ps

module tb;
   import tsma_pkg::*;

   localparam int RandomRequests = 1430;
   localparam int QuietTail      = 150;
   localparam int IdleLimit      = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles;
   bit      quiet;

   ternary_sign_magnitude_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   tsma_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // build a magnitude in one of several shapes: clean trits, raw codes, edges
   function automatic logic [FieldBits-1:0] random_digits();
      logic [FieldBits-1:0] d;
      int                   top;
      d = '0;
      case ($urandom_range(0, 7))
         0: d = '0;
         1: d = {FieldBits{1'b1}};
         2: d = FieldBits'({$urandom, $urandom});
         3: begin
            top = $urandom_range(0, 4);
            for (int i = 0; i <= top; i++) d[2*i +: 2] = 2'($urandom_range(0, 2));
         end
         4: d = {FieldTrits{2'b10}};
         default: begin
            top = $urandom_range(0, FieldTrits - 1);
            for (int i = 0; i <= top; i++) d[2*i +: 2] = 2'($urandom_range(0, 2));
         end
      endcase
      return d;
   endfunction

   // hold the request until it is taken, with random gaps before it
   task automatic send_request(logic [2:0] mode, logic an, logic [FieldBits-1:0] ad,
                               logic bn, logic [FieldBits-1:0] bd);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: mode, a_negative: an, a_digits: ad, b_negative: bn, b_digits: bd};
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      logic [FieldBits-1:0] all_twos;
      logic [FieldBits-1:0] ones;
      all_twos = {FieldTrits{2'b10}};
      ones = {FieldBits{1'b1}};
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int m = ModeAdd; m <= ModeCmp; m++) begin
         send_request(3'(m), 1'b0, all_twos, 1'b0, all_twos);
         send_request(3'(m), 1'b1, 52'd1, 1'b0, 52'd0);
         send_request(3'(m), 1'b1, 52'd0, 1'b0, 52'd0);
         send_request(3'(m), 1'b0, ones, 1'b1, 52'h5);
      end
      send_request(ModeSub, 1'b0, 52'd4, 1'b0, 52'd8);
      send_request(ModeDiv, 1'b1, all_twos, 1'b0, 52'd2);
      send_request(ModeCmp, 1'b1, 52'd5, 1'b1, 52'd6);
      send_request(3'd5, 1'b1, ones, 1'b1, ones);
      send_request(3'd7, 1'b0, 52'd1, 1'b0, 52'd2);
      for (int n = 0; n < RandomRequests; n++) begin
         if (n == RandomRequests - 200) quiet = 1'b1;
         send_request($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4)),
                      1'($urandom), random_digits(), 1'($urandom), random_digits());
      end
      req_valid <= 1'b0;
      // let the checker count the last request before waiting on it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (QuietTail) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // response side stalls in bursts
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // advance the idle counter only while nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
